@@ rtl/ftsm_pkg.sv @@
// shared types and constants for the fan tach and setpoint monitor
package ftsm_pkg;

    localparam int EDGE_TIME_W   = 32;
    localparam int ADC_W         = 10;
    localparam int SPEED_W       = 16;
    localparam int SETPOINT_W    = 14;
    localparam int MARGIN_W      = 14;
    localparam int SAMPLES_W     = 5;
    localparam int DEADBAND_W    = 12;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 14;
    localparam int SUM_W         = 16;
    localparam int EDGES_W       = 2;
    localparam int PRODUCT_W     = SETPOINT_W + ADC_W;
    localparam int STEP_CNT_W    = 5;

    localparam logic [EDGE_TIME_W-1:0] SPEED_NUMERATOR = 32'd30000000;
    localparam logic [EDGE_TIME_W-1:0] ADC_FULL_SCALE  = 32'd1015;
    localparam logic [SPEED_W-1:0]     SPEED_MAX       = 16'hFFFF;
    localparam logic [SUM_W-1:0]       SUM_MAX         = 16'hFFFF;
    localparam logic [EDGES_W-1:0]     EDGES_FULL      = 2'd2;

    localparam logic [SETPOINT_W-1:0] MAX_SPEED_RESET = 14'd4000;
    localparam logic [MARGIN_W-1:0]   MARGIN_RESET    = 14'd100;
    localparam logic [SAMPLES_W-1:0]  SAMPLES_RESET   = 5'd4;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET  = 12'd18;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MARGIN    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND  = 2'd3;

    // item kinds
    localparam logic FUNC_TACH_EDGE = 1'b0;
    localparam logic FUNC_POT_SAMPLE = 1'b1;

    // fault codes
    localparam logic FAULT_NONE      = 1'b0;
    localparam logic FAULT_OVERSPEED = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [EDGE_TIME_W-1:0] edge_time_us;
        logic [ADC_W-1:0]       adc_sample;
    } in_item_t;

    typedef struct packed {
        logic [SPEED_W-1:0]    speed_rpm;
        logic [SETPOINT_W-1:0] setpoint_rpm;
        logic                  fault_active;
        logic                  fault_code;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_SPEED = 2'd0,
        OP_SCALE = 2'd1,
        OP_AVG   = 2'd2
    } div_op_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

@@ rtl/fan_tach_and_setpoint_monitor_unit.sv @@
// top level: tach speed, overspeed fault and potentiometer setpoint with a shared divider
//
//  channel | ports                               | payload
//  --------+-------------------------------------+---------------------------------
//  input   | s_valid, s_ready, s_data            | in_item_t (func, time, sample)
//  result  | m_valid, m_ready, m_data            | out_item_t (speed, setpoint, fault)
//  config  | cfg_valid, cfg_ready, cfg_index/wdata| register index 0..3, 14-bit data
//
//  one request gives one result. a division (tach speed, sample scaling, average)
//  runs through one restoring divider at one quotient bit per cycle, in the divide state,
//  then the finish state and the done state; sample scaling passes a multiply state first.
//  requests with no division go from idle straight to the done state; requests are taken in idle only.
//  reset is synchronous, active low, and restores the register defaults.
//  a finished result waits in the output register, the next request is taken meanwhile.
module fan_tach_and_setpoint_monitor_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ftsm_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ftsm_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ftsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ftsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ftsm_pkg::*;

    state_t                  state_reg, state_next;
    div_op_t                 op_reg, op_next;
    logic [ADC_W-1:0]        adc_reg, adc_next;

    logic [SETPOINT_W-1:0]   max_speed_reg, max_speed_next;
    logic [MARGIN_W-1:0]     margin_reg, margin_next;
    logic [SAMPLES_W-1:0]    samples_reg, samples_next;
    logic [DEADBAND_W-1:0]   deadband_reg, deadband_next;

    logic [EDGE_TIME_W-1:0]  newest_reg, newest_next;
    logic [EDGE_TIME_W-1:0]  older_reg, older_next;
    logic [EDGES_W-1:0]      edges_reg, edges_next;
    logic [SPEED_W-1:0]      held_speed_reg, held_speed_next;
    logic [SAMPLES_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [SETPOINT_W-1:0]   setpoint_reg, setpoint_next;
    logic                    fault_reg, fault_next;

    logic [EDGE_TIME_W-1:0]  quo_reg, quo_next;
    logic [EDGE_TIME_W-1:0]  rem_reg, rem_next;
    logic [EDGE_TIME_W-1:0]  divisor_reg, divisor_next;
    logic [STEP_CNT_W-1:0]   step_reg, step_next;

    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    logic                    s_accept;
    logic                    out_free;
    logic [EDGES_W-1:0]      edges_inc;
    logic [EDGE_TIME_W-1:0]  period;
    logic [SPEED_W:0]        speed_limit;
    logic                    fault_hit;
    logic [SAMPLES_W-1:0]    n_eff;
    logic [EDGE_TIME_W:0]    rem_shift;
    logic [EDGE_TIME_W:0]    rem_sub;
    logic                    rem_ge;
    logic [PRODUCT_W-1:0]    product;
    logic [SUM_W:0]          sum_add;
    logic [SUM_W-1:0]        avg;
    logic [SUM_W-1:0]        sp_ext;
    logic [SUM_W-1:0]        sp_diff;
    logic                    in_deadband;
    logic [SETPOINT_W-1:0]   sp_clamped;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid & s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = ~m_valid_reg | m_ready;

    assign edges_inc   = (edges_reg == EDGES_FULL) ? EDGES_FULL : edges_reg + 2'd1;
    assign period      = s_data.edge_time_us - newest_reg;
    assign speed_limit = {3'b000, max_speed_reg} + {3'b000, margin_reg};
    assign fault_hit   = {1'b0, held_speed_reg} > speed_limit;
    assign n_eff       = (samples_reg == '0) ? 5'd1 : samples_reg;

    // one restoring division step
    assign rem_shift = {rem_reg, quo_reg[EDGE_TIME_W-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};

    assign product = max_speed_reg * adc_reg;
    assign sum_add = {1'b0, sum_reg} + {1'b0, quo_reg[SUM_W-1:0]};
    assign avg     = quo_reg[SUM_W-1:0];
    assign sp_ext  = {2'b00, setpoint_reg};
    assign sp_diff = (sp_ext >= avg) ? (sp_ext - avg) : (avg - sp_ext);
    assign in_deadband = sp_diff <= {4'b0000, deadband_reg};
    assign sp_clamped  = (setpoint_reg > max_speed_reg) ? max_speed_reg : setpoint_reg;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        adc_next        = adc_reg;
        max_speed_next  = max_speed_reg;
        margin_next     = margin_reg;
        samples_next    = samples_reg;
        deadband_next   = deadband_reg;
        newest_next     = newest_reg;
        older_next      = older_reg;
        edges_next      = edges_reg;
        held_speed_next = held_speed_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        setpoint_next   = setpoint_reg;
        fault_next      = fault_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        step_next       = step_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_SPEED: max_speed_next = cfg_wdata[SETPOINT_W-1:0];
                REG_MARGIN:    margin_next    = cfg_wdata[MARGIN_W-1:0];
                REG_SAMPLES:   samples_next   = cfg_wdata[SAMPLES_W-1:0];
                REG_DEADBAND:  deadband_next  = cfg_wdata[DEADBAND_W-1:0];
                default:       max_speed_next = max_speed_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    adc_next = s_data.adc_sample;
                    if (s_data.func == FUNC_TACH_EDGE) begin
                        // overspeed check uses the speed of the pair held so far
                        if (fault_hit) begin
                            fault_next    = 1'b1;
                            setpoint_next = '0;
                        end
                        older_next  = newest_reg;
                        newest_next = s_data.edge_time_us;
                        edges_next  = edges_inc;
                        state_next  = ST_DONE;
                        if (edges_inc != EDGES_FULL) begin
                            held_speed_next = '0;
                        end else if (s_data.edge_time_us < newest_reg) begin
                            // timestamp wrapped: keep last speed
                            held_speed_next = held_speed_reg;
                        end else if (period == '0) begin
                            held_speed_next = SPEED_MAX;
                        end else begin
                            quo_next     = SPEED_NUMERATOR;
                            rem_next     = '0;
                            divisor_next = period;
                            step_next    = '0;
                            op_next      = OP_SPEED;
                            state_next   = ST_DIV;
                        end
                    end else if (!fault_reg) begin
                        if (count_reg < n_eff) begin
                            op_next    = OP_SCALE;
                            state_next = ST_MUL;
                        end else begin
                            quo_next     = {16'h0000, sum_reg};
                            rem_next     = '0;
                            divisor_next = {27'd0, n_eff};
                            step_next    = '0;
                            op_next      = OP_AVG;
                            state_next   = ST_DIV;
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL: begin
                quo_next     = {8'h00, product};
                rem_next     = '0;
                divisor_next = ADC_FULL_SCALE;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                rem_next  = rem_ge ? rem_sub[EDGE_TIME_W-1:0] : rem_shift[EDGE_TIME_W-1:0];
                quo_next  = {quo_reg[EDGE_TIME_W-2:0], rem_ge};
                step_next = step_reg + 5'd1;
                if (step_reg == '1) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                state_next = ST_DONE;
                case (op_reg)
                    OP_SPEED: begin
                        held_speed_next = (quo_reg[EDGE_TIME_W-1:SPEED_W] != '0) ?
                                          SPEED_MAX : quo_reg[SPEED_W-1:0];
                    end
                    OP_SCALE: begin
                        sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                        count_next = count_reg + 5'd1;
                    end
                    OP_AVG: begin
                        if (!in_deadband) begin
                            setpoint_next = (avg > {2'b00, max_speed_reg}) ?
                                            max_speed_reg : avg[SETPOINT_W-1:0];
                        end
                        count_next = '0;
                        sum_next   = '0;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.speed_rpm     = held_speed_reg;
                    m_data_next.setpoint_rpm  = fault_reg ? '0 : sp_clamped;
                    m_data_next.fault_active  = fault_reg;
                    m_data_next.fault_code    = fault_reg ? FAULT_OVERSPEED : FAULT_NONE;
                    state_next                = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            max_speed_reg  <= MAX_SPEED_RESET;
            margin_reg     <= MARGIN_RESET;
            samples_reg    <= SAMPLES_RESET;
            deadband_reg   <= DEADBAND_RESET;
            newest_reg     <= '0;
            older_reg      <= '0;
            edges_reg      <= '0;
            held_speed_reg <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            setpoint_reg   <= '0;
            fault_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            max_speed_reg  <= max_speed_next;
            margin_reg     <= margin_next;
            samples_reg    <= samples_next;
            deadband_reg   <= deadband_next;
            newest_reg     <= newest_next;
            older_reg      <= older_next;
            edges_reg      <= edges_next;
            held_speed_reg <= held_speed_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            setpoint_reg   <= setpoint_next;
            fault_reg      <= fault_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        adc_reg     <= adc_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        step_reg    <= step_next;
        m_data_reg  <= m_data_next;
    end

endmodule
